### hdl/integer_to_ascii_formatter_macros.svh
// Assertion macros for the integer-to-ASCII formatter checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Check a condition at every edge outside reset.
`define I2A_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a condition implies another one at the next edge, outside reset.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check the state that follows an edge with reset asserted.
`define I2A_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

### hdl/i2a_pkg.sv
// Shared types, constants and functions of the integer-to-ASCII formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2a_pkg;

    localparam int BIN_W      = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int ACC_W      = BCD_W + BIN_W;
    localparam int N_STAGES   = 8;
    localparam int STEPS      = BIN_W / N_STAGES;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_LOWER = 7'h61;
    localparam logic [6:0] CH_UPPER = 7'h41;

    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_HEXL = 2'd2,
        OP_HEXU = 2'd3
    } t_op;

    typedef logic [DEC_DIGITS-1:0][3:0] t_digits;
    typedef logic [HEX_DIGITS-1:0][3:0] t_nibs;

    // One number on its way through the conversion pipeline
    typedef struct packed {
        t_op              op;
        logic             neg;
        logic [BIN_W-1:0] value;
        logic [ACC_W-1:0] acc;   // BCD digits above, remaining binary bits below
    } t_item;

    // One shift-and-add-3 step of the binary to BCD conversion
    function automatic logic [ACC_W-1:0] dabble_step(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] r;
        r = acc;
        for (int d = 0; d < DEC_DIGITS; d++) begin
            if (r[BIN_W + 4*d +: 4] >= 4'd5) begin
                r[BIN_W + 4*d +: 4] = r[BIN_W + 4*d +: 4] + 4'd3;
            end
        end
        return {r[ACC_W-2:0], 1'b0};
    endfunction

    // Map one nibble to its hex character
    function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [6:0] base;
        base = upper ? CH_UPPER : CH_LOWER;
        if (nib < 4'd10) begin
            return CH_ZERO + {3'b000, nib};
        end
        return base + {3'b000, nib - 4'd10};
    endfunction

endpackage

`default_nettype wire

### hdl/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter, top level. The serializer emits a number's characters
// (1 to 11 decimal, 8 hex) one per cycle while the output is not stalled, and takes
// the next number with the last character; the 8-stage BCD pipeline (4 steps a stage)
// behind the entry register accepts a number every cycle unless stalled.
// Reset (synchronous, active low) empties all stages and the output register.
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_out_char,
    output logic             o_last
);
    import i2a_pkg::*;

    logic  w_valid [N_STAGES+1];
    logic  w_ready [N_STAGES+1];
    t_item w_item  [N_STAGES+1];

    // Register the transaction and form the magnitude
    i2a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .i_value (i_value),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_item  (w_item[0])
    );

    // Convert to BCD over the stage chain
    for (genvar g = 0; g < N_STAGES; g++) begin : g_dabble
        i2a_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // Emit characters
    i2a_serializer u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[N_STAGES]),
        .o_ready    (w_ready[N_STAGES]),
        .i_item     (w_item[N_STAGES]),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

### hdl/i2a_front.sv
// Entry stage: registers the accepted transaction and forms sign and magnitude.
// Depends on i2a_pkg.
`default_nettype none

module i2a_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_op,
    input  wire logic [31:0]   i_value,
    output logic               o_valid,
    input  wire logic          i_ready,
    output i2a_pkg::t_item     o_item
);
    import i2a_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // Take the two's complement magnitude of a negative signed value
    always_comb begin
        n_item.op    = t_op'(i_op);
        n_item.neg   = (t_op'(i_op) == OP_SDEC) && i_value[BIN_W-1];
        n_item.value = i_value;
        n_item.acc   = {{BCD_W{1'b0}}, (n_item.neg ? (~i_value + 32'd1) : i_value)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### hdl/i2a_dabble_stage.sv
// One pipeline stage of the binary to BCD converter: STEPS (4) shift-and-add-3 steps.
// Depends on i2a_pkg.
`default_nettype none

module i2a_dabble_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  i2a_pkg::t_item     i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output i2a_pkg::t_item     o_item
);
    import i2a_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;

    // Run this stage's share of the conversion steps
    always_comb begin
        n_item = i_item;
        for (int s = 0; s < STEPS; s++) begin
            n_item.acc = dabble_step(n_item.acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### hdl/i2a_serializer.sv
// Output serializer: holds one converted number and emits its characters
// into a registered output, one per cycle while not stalled. Depends on i2a_pkg.
`default_nettype none

module i2a_serializer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  i2a_pkg::t_item     i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [6:0]         o_out_char,
    output logic               o_last
);
    import i2a_pkg::*;

    logic       r_active;
    logic       r_sign;
    logic [3:0] r_pos;
    t_op        r_op;
    t_digits    r_digits;
    t_nibs      r_nibs;
    logic       r_ovalid;
    logic [6:0] r_char;
    logic       r_last;

    t_digits    w_in_digits;
    logic [3:0] w_top;
    logic       w_in_hex;
    logic       w_hex;
    logic       w_adv;
    logic       w_emit;
    logic       w_is_last;
    logic       w_release;
    logic       w_load;
    logic [6:0] w_char;

    assign w_in_digits = t_digits'(i_item.acc[ACC_W-1 -: BCD_W]);
    assign w_in_hex    = (i_item.op == OP_HEXL) || (i_item.op == OP_HEXU);
    assign w_hex       = (r_op == OP_HEXL) || (r_op == OP_HEXU);

    // Find the most significant nonzero digit; zero keeps a single digit
    always_comb begin
        w_top = 4'd0;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (w_in_digits[i] != 4'd0) begin
                w_top = 4'(i);
            end
        end
    end

    assign w_adv     = !r_ovalid || i_ready;
    assign w_emit    = r_active && w_adv;
    assign w_is_last = !r_sign && (r_pos == 4'd0);
    assign w_release = w_emit && w_is_last;
    assign o_ready   = !r_active || w_release;
    assign w_load    = i_valid && o_ready;

    // Select the current character: sign first, then digits from the top
    always_comb begin
        if (r_sign) begin
            w_char = CH_MINUS;
        end else if (w_hex) begin
            w_char = hex_char(r_nibs[r_pos[2:0]], r_op == OP_HEXU);
        end else begin
            w_char = CH_ZERO + {3'b000, r_digits[r_pos]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_active <= 1'b1;
            end else if (w_release) begin
                r_active <= 1'b0;
            end
            if (w_adv) begin
                r_ovalid <= r_active;
            end
        end
    end

    // Advance through the number; a new transaction takes over on release
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= w_char;
            r_last <= w_is_last;
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_pos != 4'd0) begin
                r_pos <= r_pos - 4'd1;
            end
        end
        if (w_load) begin
            r_op     <= i_item.op;
            r_sign   <= i_item.neg;
            r_pos    <= w_in_hex ? 4'(HEX_DIGITS - 1) : w_top;
            r_digits <= w_in_digits;
            r_nibs   <= t_nibs'(i_item.value);
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_char = r_char;
    assign o_last     = r_last;

endmodule

`default_nettype wire

### hdl/i2a_checker.sv
// Port-level checker for the integer-to-ASCII formatter, bound to the top level.
// Depends on integer_to_ascii_formatter_macros.svh.
`default_nettype none

`include "integer_to_ascii_formatter_macros.svh"

module i2a_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_op,
    input wire logic [31:0] i_value,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [6:0]  o_out_char,
    input wire logic        o_last
);

    logic w_char_ok;

    // Digits, hex letters of either case, or the minus sign
    assign w_char_ok = (o_out_char >= 7'h30 && o_out_char <= 7'h39)
                    || (o_out_char >= 7'h61 && o_out_char <= 7'h66)
                    || (o_out_char >= 7'h41 && o_out_char <= 7'h46)
                    || (o_out_char == 7'h2d);

    `I2A_ASSERT_RESET(a_reset_empty, !o_valid, "output valid after reset")
    `I2A_ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_out_char) && $stable(o_last), "stalled output transaction changed")
    `I2A_ASSERT_NEXT(a_in_hold, i_valid && !o_ready,
        i_valid && $stable(i_op) && $stable(i_value), "stalled input transaction changed")
    `I2A_ASSERT_ALWAYS(a_char_set, !o_valid || w_char_ok, "character outside the output set")
    `I2A_ASSERT_ALWAYS(a_minus_not_last, !(o_valid && o_out_char == 7'h2d && o_last),
        "minus sign flagged as last")

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_op       (i_op),
    .i_value    (i_value),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_char (o_out_char),
    .o_last     (o_last)
);

`default_nettype wire
